@@ rtl/core/tfwc_pkg.sv @@
// tfwc_pkg: shared types, constants and the sequencer program of the
// two-finger wrench combiner.
// Depends on nothing; used by two_finger_wrench_combiner_top.
package tfwc_pkg;

    // request payloads
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic [62:0]        sample_time;
        logic signed [31:0] finger_distance;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] total_force_x;
        logic signed [31:0] total_force_y;
        logic signed [31:0] total_force_z;
        logic signed [31:0] total_torque_x;
        logic signed [31:0] total_torque_y;
        logic signed [31:0] total_torque_z;
        logic [30:0]        squeeze_force;
        logic [62:0]        out_time;
    } result_t;

    // sample modes
    localparam logic [1:0] MODE_FINGER0 = 2'd0;
    localparam logic [1:0] MODE_FINGER1 = 2'd1;
    localparam logic [1:0] MODE_DIST    = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1_ROW0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1_ROW1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1_ROW2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVER_OFFSET = 3'd6;

    // reset values: identity for finger 0, diag(-1,1,-1) for finger 1
    localparam logic [47:0] ROT0_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [47:0] ROT0_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [47:0] ROT0_ROW2_RST = 48'h4000_0000_0000;
    localparam logic [47:0] ROT1_ROW0_RST = 48'h0000_0000_C000;
    localparam logic [47:0] ROT1_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [47:0] ROT1_ROW2_RST = 48'hC000_0000_0000;
    localparam logic signed [31:0] LEVER_RST = 32'sd2621;

    // timestamp
    localparam logic [62:0] TIME_STEP = 63'd1000;
    localparam logic [62:0] TIME_MAX  = {63{1'b1}};

    // working vector slots
    localparam logic [2:0] V_FX = 3'd0;
    localparam logic [2:0] V_FY = 3'd1;
    localparam logic [2:0] V_FZ = 3'd2;
    localparam logic [2:0] V_TX = 3'd3;
    localparam logic [2:0] V_TY = 3'd4;
    localparam logic [2:0] V_TZ = 3'd5;

    // sequencer
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd22;

    typedef enum logic [1:0] {B_NONE, B_LEVER, B_ROT} b_src_t;
    typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_LOAD_NEG, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {WB_NONE, WB_TORQUE, WB_ROT} wb_op_t;
    typedef enum logic {SEQ_NEXT, SEQ_EMIT} seq_op_t;

    typedef struct packed {
        logic [2:0] a_sel;
        b_src_t     b_src;
        logic [1:0] row;
        logic [1:0] col;
        acc_op_t    acc_op;
        wb_op_t     wb_op;
        logic [2:0] wb_idx;
        seq_op_t    seq_op;
    } ctrl_t;

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sh0000_0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -64'sh0000_0000_8000_0000)
                r = -32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    function automatic ctrl_t cw(input logic [2:0] a, input b_src_t b, input logic [1:0] row,
                                 input logic [1:0] col, input acc_op_t acc, input wb_op_t wb,
                                 input logic [2:0] idx, input seq_op_t seq);
        ctrl_t w;
        begin
            w.a_sel  = a;
            w.b_src  = b;
            w.row    = row;
            w.col    = col;
            w.acc_op = acc;
            w.wb_op  = wb;
            w.wb_idx = idx;
            w.seq_op = seq;
            return w;
        end
    endfunction

    // program: multiply issues in a step, accumulate uses the previous
    // product, write-back uses the previous accumulator
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            case (step)
                5'd0:  w = cw(V_FY, B_LEVER, 2'd0, 2'd0, ACC_NOP, WB_NONE, V_FX, SEQ_NEXT);
                5'd1:  w = cw(V_FX, B_LEVER, 2'd0, 2'd0, ACC_LOAD_NEG, WB_NONE, V_FX,
                              SEQ_NEXT);
                5'd2:  w = cw(V_FX, B_ROT, 2'd0, 2'd0, ACC_LOAD, WB_TORQUE, V_TX, SEQ_NEXT);
                5'd3:  w = cw(V_FY, B_ROT, 2'd0, 2'd1, ACC_LOAD, WB_TORQUE, V_TY, SEQ_NEXT);
                5'd4:  w = cw(V_FZ, B_ROT, 2'd0, 2'd2, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd5:  w = cw(V_FX, B_ROT, 2'd1, 2'd0, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd6:  w = cw(V_FY, B_ROT, 2'd1, 2'd1, ACC_LOAD, WB_ROT, 3'd0, SEQ_NEXT);
                5'd7:  w = cw(V_FZ, B_ROT, 2'd1, 2'd2, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd8:  w = cw(V_FX, B_ROT, 2'd2, 2'd0, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd9:  w = cw(V_FY, B_ROT, 2'd2, 2'd1, ACC_LOAD, WB_ROT, 3'd1, SEQ_NEXT);
                5'd10: w = cw(V_FZ, B_ROT, 2'd2, 2'd2, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd11: w = cw(V_TX, B_ROT, 2'd0, 2'd0, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd12: w = cw(V_TY, B_ROT, 2'd0, 2'd1, ACC_LOAD, WB_ROT, 3'd2, SEQ_NEXT);
                5'd13: w = cw(V_TZ, B_ROT, 2'd0, 2'd2, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd14: w = cw(V_TX, B_ROT, 2'd1, 2'd0, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd15: w = cw(V_TY, B_ROT, 2'd1, 2'd1, ACC_LOAD, WB_ROT, 3'd3, SEQ_NEXT);
                5'd16: w = cw(V_TZ, B_ROT, 2'd1, 2'd2, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd17: w = cw(V_TX, B_ROT, 2'd2, 2'd0, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd18: w = cw(V_TY, B_ROT, 2'd2, 2'd1, ACC_LOAD, WB_ROT, 3'd4, SEQ_NEXT);
                5'd19: w = cw(V_TZ, B_ROT, 2'd2, 2'd2, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd20: w = cw(V_FX, B_NONE, 2'd0, 2'd0, ACC_ADD, WB_NONE, V_FX, SEQ_NEXT);
                5'd21: w = cw(V_FX, B_NONE, 2'd0, 2'd0, ACC_NOP, WB_ROT, 3'd5, SEQ_NEXT);
                5'd22: w = cw(V_FX, B_NONE, 2'd0, 2'd0, ACC_NOP, WB_NONE, V_FX, SEQ_EMIT);
                default: w = cw(V_FX, B_NONE, 2'd0, 2'd0, ACC_NOP, WB_NONE, V_FX, SEQ_EMIT);
            endcase
            return w;
        end
    endfunction

endpackage

@@ rtl/core/two_finger_wrench_combiner_top.sv @@
// two_finger_wrench_combiner_top: moves finger wrenches into the grasp
// frame and emits the summed wrench, grasp force and a monotonic stamp.
// Depends on tfwc_pkg (types, program table, saturation helper).
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) takes one request
//   at a time. mode 0 or 1 is a wrench from finger 0 or 1; mode 2 sets the
//   lever length from the finger distance; mode 3 is dropped.
//   result channel (result_valid / result_stall / result) carries one
//   result per wrench request, held in an output register.
//   cfg_write / cfg_index / cfg_data write the rotation rows and the lever
//   offset; write them only while the block is idle.
// Program:
//   a wrench request runs a 23-step program on one shared 32x32
//   multiplier (2 lever products, 18 rotation products); sample_stall
//   stays high while it runs, so the next request is taken only once
//   the program has emitted its result.
//   distance and dropped requests do not start the program.
// Stall:
//   a finished result waits in the output register; the sequencer holds on
//   its last step only if a result is still waiting there unaccepted.
// Reset:
//   rst_n resets all but the payload registers; no clearing pass is needed.
module two_finger_wrench_combiner_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tfwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tfwc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  tfwc_pkg::sample_t                    sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tfwc_pkg::result_t                    result
);
    import tfwc_pkg::*;

    // control
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] pc_reg, pc_next;
    logic              finger_reg, finger_next;
    ctrl_t             uword;
    logic              accept;
    logic              out_free;
    logic              emit;

    // datapath
    logic signed [31:0] vin_reg [6];
    logic signed [31:0] vin_next [6];
    logic [62:0]        stamp_reg, stamp_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] a_op, b_op;
    logic [47:0]        rot_row;
    logic [15:0]        rot_entry;
    logic signed [31:0] wb_src;
    logic signed [31:0] rot_val, torque_val;

    // kept state
    logic signed [31:0] wrench_a_reg [6];
    logic signed [31:0] wrench_a_next [6];
    logic signed [31:0] wrench_b_reg [6];
    logic signed [31:0] wrench_b_next [6];
    logic signed [31:0] raw_fz_a_reg, raw_fz_a_next;
    logic signed [31:0] raw_fz_b_reg, raw_fz_b_next;
    logic signed [31:0] lever_z_reg, lever_z_next;
    logic [62:0]        last_time_reg, last_time_next;

    // configuration
    logic [47:0]        rot_reg [2][3];
    logic [47:0]        rot_next [2][3];
    logic signed [31:0] lever_offset_reg, lever_offset_next;

    // output register
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;
    logic [32:0]        abs_a, abs_b, abs_min;
    logic [33:0]        grasp_wide;

    // handshakes
    assign uword        = ucode(pc_reg);
    assign sample_stall = busy_reg;
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !res_valid_reg || !result_stall;
    assign emit         = busy_reg && (uword.seq_op == SEQ_EMIT) && out_free;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // step counter
    always_comb
    begin
        busy_next   = busy_reg;
        pc_next     = pc_reg;
        finger_next = finger_reg;
        if (busy_reg)
        begin
            case (uword.seq_op)
                SEQ_NEXT: pc_next = pc_reg + 1'b1;
                SEQ_EMIT:
                begin
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                        pc_next   = '0;
                    end
                end
                default: pc_next = '0;
            endcase
        end
        else if (accept && (sample.mode == MODE_FINGER0 || sample.mode == MODE_FINGER1))
        begin
            busy_next   = 1'b1;
            pc_next     = '0;
            finger_next = (sample.mode == MODE_FINGER1);
        end
    end

    // multiplier operand a
    always_comb
    begin
        case (uword.a_sel)
            V_FX:    a_op = vin_reg[0];
            V_FY:    a_op = vin_reg[1];
            V_FZ:    a_op = vin_reg[2];
            V_TX:    a_op = vin_reg[3];
            V_TY:    a_op = vin_reg[4];
            V_TZ:    a_op = vin_reg[5];
            default: a_op = vin_reg[0];
        endcase
    end

    // multiplier operand b: lever length or one rotation entry
    always_comb
    begin
        case (uword.row)
            2'd1:    rot_row = rot_reg[finger_reg][1];
            2'd2:    rot_row = rot_reg[finger_reg][2];
            default: rot_row = rot_reg[finger_reg][0];
        endcase
        case (uword.col)
            2'd1:    rot_entry = rot_row[31:16];
            2'd2:    rot_entry = rot_row[47:32];
            default: rot_entry = rot_row[15:0];
        endcase
        if (uword.b_src == B_LEVER)
            b_op = lever_z_reg;
        else
            b_op = 32'(signed'(rot_entry));
    end

    // multiply and accumulate
    always_comb
    begin
        if (busy_reg && uword.b_src != B_NONE)
            prod_next = 64'(a_op) * 64'(b_op);
        else
            prod_next = prod_reg;
        case (uword.acc_op)
            ACC_LOAD:     acc_next = prod_reg;
            ACC_LOAD_NEG: acc_next = -prod_reg;
            ACC_ADD:      acc_next = acc_reg + prod_reg;
            default:      acc_next = acc_reg;
        endcase
        if (!busy_reg)
            acc_next = acc_reg;
    end

    // write-back rounding: Q18.30 to Q16.16, lever Q32.32 to Q16.16 plus moment
    always_comb
    begin
        case (uword.wb_idx)
            V_TY:    wb_src = vin_reg[4];
            default: wb_src = vin_reg[3];
        endcase
        rot_val    = sat32((acc_reg + 64'sd8192) >>> 14);
        torque_val = sat32(((acc_reg + 64'sd32768) >>> 16) + 64'(wb_src));
    end

    // working vector
    always_comb
    begin
        vin_next   = vin_reg;
        stamp_next = stamp_reg;
        if (accept)
        begin
            vin_next[0] = sample.force_x;
            vin_next[1] = sample.force_y;
            vin_next[2] = sample.force_z;
            vin_next[3] = sample.torque_x;
            vin_next[4] = sample.torque_y;
            vin_next[5] = sample.torque_z;
            stamp_next  = sample.sample_time;
        end
        else if (busy_reg && uword.wb_op == WB_TORQUE)
        begin
            if (uword.wb_idx == V_TY)
                vin_next[4] = torque_val;
            else
                vin_next[3] = torque_val;
        end
    end

    // stored wrenches
    always_comb
    begin
        wrench_a_next = wrench_a_reg;
        wrench_b_next = wrench_b_reg;
        for (int i = 0; i < 6; i++)
        begin
            if (busy_reg && uword.wb_op == WB_ROT && uword.wb_idx == 3'(i))
            begin
                if (finger_reg)
                    wrench_b_next[i] = rot_val;
                else
                    wrench_a_next[i] = rot_val;
            end
        end
    end

    // raw z forces and lever length
    always_comb
    begin
        raw_fz_a_next = raw_fz_a_reg;
        raw_fz_b_next = raw_fz_b_reg;
        lever_z_next  = lever_z_reg;
        if (accept)
        begin
            case (sample.mode)
                MODE_FINGER0: raw_fz_a_next = sample.force_z;
                MODE_FINGER1: raw_fz_b_next = sample.force_z;
                MODE_DIST:
                    lever_z_next = sat32(((64'(sample.finger_distance) + 64'sd1) >>> 1)
                                         + 64'(lever_offset_reg));
                default: lever_z_next = lever_z_reg;
            endcase
        end
    end

    // monotonic timestamp
    always_comb
    begin
        last_time_next = last_time_reg;
        if (emit)
        begin
            if (stamp_reg > last_time_reg)
                last_time_next = stamp_reg;
            else if (last_time_reg > TIME_MAX - TIME_STEP)
                last_time_next = TIME_MAX;
            else
                last_time_next = last_time_reg + TIME_STEP;
        end
    end

    // result assembly
    always_comb
    begin
        abs_a      = raw_fz_a_reg[31] ? -33'(raw_fz_a_reg) : 33'(raw_fz_a_reg);
        abs_b      = raw_fz_b_reg[31] ? -33'(raw_fz_b_reg) : 33'(raw_fz_b_reg);
        abs_min    = (abs_a < abs_b) ? abs_a : abs_b;
        grasp_wide = {abs_min, 1'b0};
        res_next                = res_reg;
        res_next.total_force_x  = sat32(64'(wrench_a_reg[0]) + 64'(wrench_b_reg[0]));
        res_next.total_force_y  = sat32(64'(wrench_a_reg[1]) + 64'(wrench_b_reg[1]));
        res_next.total_force_z  = sat32(64'(wrench_a_reg[2]) + 64'(wrench_b_reg[2]));
        res_next.total_torque_x = sat32(64'(wrench_a_reg[3]) + 64'(wrench_b_reg[3]));
        res_next.total_torque_y = sat32(64'(wrench_a_reg[4]) + 64'(wrench_b_reg[4]));
        res_next.total_torque_z = sat32(64'(wrench_a_reg[5]) + 64'(wrench_b_reg[5]));
        res_next.squeeze_force  = (grasp_wide > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                : grasp_wide[30:0];
        res_next.out_time       = last_time_next;
        if (!emit)
            res_next = res_reg;
        if (emit)
            res_valid_next = 1'b1;
        else if (result_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    // configuration writes
    always_comb
    begin
        rot_next          = rot_reg;
        lever_offset_next = lever_offset_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROT0_ROW0:    rot_next[0][0] = cfg_data;
                CFG_ROT0_ROW1:    rot_next[0][1] = cfg_data;
                CFG_ROT0_ROW2:    rot_next[0][2] = cfg_data;
                CFG_ROT1_ROW0:    rot_next[1][0] = cfg_data;
                CFG_ROT1_ROW1:    rot_next[1][1] = cfg_data;
                CFG_ROT1_ROW2:    rot_next[1][2] = cfg_data;
                CFG_LEVER_OFFSET: lever_offset_next = cfg_data[31:0];
                default:          lever_offset_next = lever_offset_reg;
            endcase
        end
    end

    // control and kept state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pc_reg           <= '0;
            finger_reg       <= 1'b0;
            res_valid_reg    <= 1'b0;
            wrench_a_reg     <= '{default: '0};
            wrench_b_reg     <= '{default: '0};
            raw_fz_a_reg     <= '0;
            raw_fz_b_reg     <= '0;
            lever_z_reg      <= LEVER_RST;
            last_time_reg    <= '0;
            rot_reg[0][0]    <= ROT0_ROW0_RST;
            rot_reg[0][1]    <= ROT0_ROW1_RST;
            rot_reg[0][2]    <= ROT0_ROW2_RST;
            rot_reg[1][0]    <= ROT1_ROW0_RST;
            rot_reg[1][1]    <= ROT1_ROW1_RST;
            rot_reg[1][2]    <= ROT1_ROW2_RST;
            lever_offset_reg <= '0;
        end
        else
        begin
            busy_reg         <= busy_next;
            pc_reg           <= pc_next;
            finger_reg       <= finger_next;
            res_valid_reg    <= res_valid_next;
            wrench_a_reg     <= wrench_a_next;
            wrench_b_reg     <= wrench_b_next;
            raw_fz_a_reg     <= raw_fz_a_next;
            raw_fz_b_reg     <= raw_fz_b_next;
            lever_z_reg      <= lever_z_next;
            last_time_reg    <= last_time_next;
            rot_reg          <= rot_next;
            lever_offset_reg <= lever_offset_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vin_reg   <= vin_next;
        stamp_reg <= stamp_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    // a new result appears only from the last program step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(busy_reg) && $past(pc_reg) == LAST_STEP)
        else $error("result raised outside the emit step");

    // the emit step holds while a result still waits unaccepted
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && uword.seq_op == SEQ_EMIT && result_valid && result_stall
        |=> busy_reg && result_valid)
        else $error("waiting result overwritten");

    // output stamps never go backward
    assert property (@(posedge clk) disable iff (!rst_n)
        last_time_reg >= $past(last_time_reg))
        else $error("timestamp decreased");

    // program counter stays inside the program
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= LAST_STEP)
        else $error("step counter out of range");

endmodule

@@ bench/tb_grasp_pkg.sv @@
`timescale 1ns / 100ps
// tb_grasp_pkg: expected-result tracker for the wrench combiner bench.
// Depends on tfwc_pkg for the request and result structs and register codes.
package tb_grasp_pkg;

    import tfwc_pkg::*;

    // codes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;
    localparam logic [1:0]           MODE_SPARE = 2'd3;

    class grasp_tracker;

        // mirrored registers and block state
        logic [47:0]        rot_rows [2][3];
        logic signed [31:0] lever_offset;
        logic signed [31:0] lever_len;
        logic signed [31:0] held_wrench [2][6];
        logic signed [31:0] held_fz [2];
        logic [62:0]        last_stamp;

        result_t expected_totals [$];
        int      failures;

        function new();
            rot_rows[0][0] = ROT0_ROW0_RST;
            rot_rows[0][1] = ROT0_ROW1_RST;
            rot_rows[0][2] = ROT0_ROW2_RST;
            rot_rows[1][0] = ROT1_ROW0_RST;
            rot_rows[1][1] = ROT1_ROW1_RST;
            rot_rows[1][2] = ROT1_ROW2_RST;
            lever_offset = '0;
            lever_len = LEVER_RST;
            foreach (held_wrench[k, i])
                held_wrench[k][i] = '0;
            held_fz[0] = '0;
            held_fz[1] = '0;
            last_stamp = '0;
            failures = 0;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            else if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return 32'(v);
        endfunction

        // add half an lsb, then floor shift
        function longint round_half_up(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        // one 3x3 rotation of a Q16.16 vector by Q2.14 entries
        function void rotate_into(int k, int base, longint v0, longint v1, longint v2);
            longint v [3];
            longint acc;
            v[0] = v0;
            v[1] = v1;
            v[2] = v2;
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += longint'($signed(rot_rows[k][i][16*j +: 16])) * v[j];
                held_wrench[k][base + i] = clamp32(round_half_up(acc, 14));
            end
        endfunction

        function logic signed [31:0] pair_sum(int i);
            return clamp32(longint'(held_wrench[0][i]) + longint'(held_wrench[1][i]));
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
            case (idx)
                CFG_ROT0_ROW0:    rot_rows[0][0] = data;
                CFG_ROT0_ROW1:    rot_rows[0][1] = data;
                CFG_ROT0_ROW2:    rot_rows[0][2] = data;
                CFG_ROT1_ROW0:    rot_rows[1][0] = data;
                CFG_ROT1_ROW1:    rot_rows[1][1] = data;
                CFG_ROT1_ROW2:    rot_rows[1][2] = data;
                CFG_LEVER_OFFSET: lever_offset = data[31:0];
                default:          ;
            endcase
        endfunction

        // update state for an accepted request and queue the totals of a wrench
        function void note_sample(sample_t s);
            longint  fx, fy, fz, t0, t1, t2, z, a, b, g;
            int      k;
            result_t r;
            case (s.mode)
                MODE_DIST:
                begin
                    lever_len = clamp32(((longint'(s.finger_distance) + 1) >>> 1)
                                        + longint'(lever_offset));
                    return;
                end
                MODE_FINGER0, MODE_FINGER1: ;
                default: return;
            endcase

            k  = (s.mode == MODE_FINGER0) ? 0 : 1;
            fx = longint'(s.force_x);
            fy = longint'(s.force_y);
            fz = longint'(s.force_z);
            z  = longint'(lever_len);

            // lever arm cross product plus sensor torque
            t0 = clamp32(round_half_up(-(z * fy), 16) + longint'(s.torque_x));
            t1 = clamp32(round_half_up(z * fx, 16) + longint'(s.torque_y));
            t2 = longint'(s.torque_z);

            held_fz[k] = s.force_z;
            rotate_into(k, 0, fx, fy, fz);
            rotate_into(k, 3, t0, t1, t2);

            // monotonic stamp
            if (s.sample_time > last_stamp)
                last_stamp = s.sample_time;
            else if (last_stamp > TIME_MAX - TIME_STEP)
                last_stamp = TIME_MAX;
            else
                last_stamp = last_stamp + TIME_STEP;

            r.total_force_x  = pair_sum(0);
            r.total_force_y  = pair_sum(1);
            r.total_force_z  = pair_sum(2);
            r.total_torque_x = pair_sum(3);
            r.total_torque_y = pair_sum(4);
            r.total_torque_z = pair_sum(5);

            // grasp force from the raw z forces
            a = (held_fz[0] < 0) ? -longint'(held_fz[0]) : longint'(held_fz[0]);
            b = (held_fz[1] < 0) ? -longint'(held_fz[1]) : longint'(held_fz[1]);
            g = 2 * ((a < b) ? a : b);
            if (g > 64'sd2147483647)
                g = 64'sd2147483647;
            r.squeeze_force = 31'(g);
            r.out_time = last_stamp;
            expected_totals.push_back(r);
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction

        function void report(string what, logic [62:0] want, logic [62:0] got);
            failures++;
            if (failures <= 10)
                $display("mismatch %0s: expected %h, got %h", what, want, got);
        endfunction

        function void compare(string what, logic [62:0] want, logic [62:0] got);
            if (want !== got)
                report(what, want, got);
        endfunction

        // check one accepted result against the oldest expectation
        function void check_total(result_t got);
            result_t want;
            if (expected_totals.size() == 0)
            begin
                report("result with no request pending", '0, got.out_time);
                return;
            end
            want = expected_totals.pop_front();
            compare("total_force_x", want.total_force_x, got.total_force_x);
            compare("total_force_y", want.total_force_y, got.total_force_y);
            compare("total_force_z", want.total_force_z, got.total_force_z);
            compare("total_torque_x", want.total_torque_x, got.total_torque_x);
            compare("total_torque_y", want.total_torque_y, got.total_torque_y);
            compare("total_torque_z", want.total_torque_z, got.total_torque_z);
            compare("squeeze_force", want.squeeze_force, got.squeeze_force);
            compare("out_time", want.out_time, got.out_time);
        endfunction

        // results that never arrived
        function void close_out();
            result_t want;
            while (expected_totals.size() != 0)
            begin
                want = expected_totals.pop_front();
                report("missing result", want.out_time, '0);
            end
        endfunction

    endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: drives wrench and distance requests with random gaps and stalls
// into two_finger_wrench_combiner_top and checks every result.
// Depends on tfwc_pkg and tb_grasp_pkg (expected-result tracker).
module tb_top;

    import tfwc_pkg::*;
    import tb_grasp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 30;
    localparam logic signed [31:0] MAXQ = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINQ = 32'sh8000_0000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   sample_valid;
    logic                   sample_stall;
    sample_t                sample;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;

    grasp_tracker model;
    bit           calm = 1'b0;
    logic [62:0]  stamp_base = 63'd10000;
    int           cycles = 0;

    two_finger_wrench_combiner_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result check on every accepted result
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            model.check_total(result);
    end

    function int draw_wait();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // receiver: holds off a result for a drawn number of cycles, or none when calm
    initial
    begin
        int hold;
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                @(posedge clk);
                while (!result_valid)
                    @(posedge clk);
                repeat (hold - 1) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(result_valid && !result_stall))
                @(posedge clk);
        end
    end

    function logic signed [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return MAXQ;
                    1: return MINQ;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
        endcase
    endfunction

    function sample_t wrench_req(logic [1:0] m, logic signed [31:0] fx, logic signed [31:0] fy,
                                 logic signed [31:0] fz, logic signed [31:0] tx,
                                 logic signed [31:0] ty, logic signed [31:0] tz,
                                 logic [62:0] stamp);
        sample_t s;
        s.mode = m;
        s.force_x = fx;
        s.force_y = fy;
        s.force_z = fz;
        s.torque_x = tx;
        s.torque_y = ty;
        s.torque_z = tz;
        s.sample_time = stamp;
        s.finger_distance = $urandom;
        return s;
    endfunction

    function sample_t dist_req(logic signed [31:0] d);
        sample_t s;
        s = wrench_req(MODE_DIST, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       {31'($urandom), 32'($urandom)});
        s.finger_distance = d;
        return s;
    endfunction

    // random request: mostly wrenches with a slowly rising stamp
    function sample_t random_req();
        sample_t s;
        int pick;
        pick = $urandom_range(0, 99);
        stamp_base = stamp_base + $urandom_range(0, 2500);
        s = wrench_req(MODE_FINGER0, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                       rand_q16(), rand_q16(), stamp_base + $urandom_range(0, 400));
        if (pick >= 98)
            s.mode = MODE_SPARE;
        else if (pick >= 92)
            s.mode = MODE_DIST;
        else if (pick >= 46)
            s.mode = MODE_FINGER1;
        if ($urandom_range(0, 3) == 0)
            s.finger_distance = $urandom;
        else
            s.finger_distance = $signed($urandom_range(0, 26214)) - 32'sd13107;
        return s;
    endfunction

    // one rotation as a signed permutation of the axes
    function logic [2:0][47:0] signed_perm();
        logic [2:0][47:0] m;
        int col [3];
        int t, tmp;
        col = '{0, 1, 2};
        for (int k = 2; k > 0; k--)
        begin
            t = $urandom_range(0, k);
            tmp = col[k];
            col[k] = col[t];
            col[t] = tmp;
        end
        m = '0;
        for (int k = 0; k < 3; k++)
            m[k][16*col[k] +: 16] = $urandom_range(0, 1) ? 16'hC000 : 16'h4000;
        return m;
    endfunction

    function logic [2:0][47:0] random_rows();
        logic [2:0][47:0] m;
        for (int k = 0; k < 3; k++)
            m[k] = 48'({$urandom, $urandom});
        return m;
    endfunction

    // send one request and note it once accepted
    task send(input sample_t s);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        model.note_sample(s);
    endtask

    // wait until the block has gone idle
    task drain();
        sample_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        model.write_register(idx, data);
    endtask

    // rows[2:0] for finger 0, rows[5:3] for finger 1
    task apply_setting(input logic [5:0][47:0] rows, input logic signed [31:0] offset);
        write_reg(CFG_ROT0_ROW0, rows[0]);
        write_reg(CFG_ROT0_ROW1, rows[1]);
        write_reg(CFG_ROT0_ROW2, rows[2]);
        write_reg(CFG_ROT1_ROW0, rows[3]);
        write_reg(CFG_ROT1_ROW1, rows[4]);
        write_reg(CFG_ROT1_ROW2, rows[5]);
        write_reg(CFG_LEVER_OFFSET, {16'($urandom), offset});
        write_reg(CFG_SPARE, 48'({$urandom, $urandom}));
        cfg_write <= 1'b0;
    endtask

    task random_phase(input int count);
        sample_t s;
        int done;
        done = 0;
        while (done < count)
        begin
            if (done % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            s = random_req();
            send(s);
            if (s.mode != MODE_SPARE)
                done++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        sample_t s;
        model = new();
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        sample_valid <= 1'b0;
        sample <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests under the reset setting
        send(wrench_req(MODE_FINGER0, 0, 0, 0, 0, 0, 0, 63'd0));
        send(wrench_req(MODE_FINGER0, MAXQ, MAXQ, MAXQ, MAXQ, MAXQ, MAXQ, 63'd5000));
        send(wrench_req(MODE_FINGER1, MINQ, MINQ, MINQ, MINQ, MINQ, MINQ, 63'd5000));
        send(wrench_req(MODE_FINGER1, -1, 1, MINQ, -1, 1, -1, 63'd100));
        send(wrench_req(MODE_FINGER0, 1, -1, MINQ, 0, 0, 0, 63'd9000));
        send(dist_req(MAXQ));
        send(wrench_req(MODE_FINGER0, MAXQ, MINQ, 65536, 0, 0, 0, 63'd9100));
        send(dist_req(MINQ));
        send(wrench_req(MODE_FINGER1, MAXQ, MAXQ, -65536, MAXQ, MINQ, 0, 63'd9100));
        send(dist_req(-1));
        send(wrench_req(MODE_FINGER0, 65536, 65536, 65536, 65536, 65536, 65536, 63'd20000));
        send(dist_req(3));
        // ignored request carrying a stamp that would pin the time
        send(wrench_req(MODE_SPARE, -1, -1, -1, -1, -1, -1, TIME_MAX));
        send(wrench_req(MODE_FINGER1, 32768, -32768, 131072, 12345, -12345, 1, 63'd20000));
        send(dist_req(5243));
        send(wrench_req(MODE_FINGER0, -1, -1, -1, -1, -1, -1, 63'd21000));

        // axis permutations, small offset
        drain();
        apply_setting({signed_perm(), signed_perm()},
                      $signed($urandom_range(0, 6554)) - 32'sd3277);
        random_phase(400);

        // extreme entries, offset at its top
        drain();
        apply_setting({{3{48'h8000_8000_8000}}, {3{48'h7FFF_7FFF_7FFF}}}, MAXQ);
        send(dist_req(MAXQ));
        random_phase(300);

        // arbitrary entries, offset at its bottom
        drain();
        apply_setting({random_rows(), random_rows()}, MINQ);
        send(dist_req(MINQ));
        random_phase(400);

        // 45 degree turn about z for finger 0
        drain();
        apply_setting({signed_perm(), 48'h4000_0000_0000, 48'h0000_2D41_2D41,
                       48'h0000_D2BF_2D41}, 32'sd0);
        random_phase(400);

        // arbitrary entries and offset
        drain();
        apply_setting({random_rows(), random_rows()}, $urandom);
        random_phase(400);

        // reset setting again, stamps in the upper half of the range
        drain();
        apply_setting({ROT1_ROW2_RST, ROT1_ROW1_RST, ROT1_ROW0_RST,
                       ROT0_ROW2_RST, ROT0_ROW1_RST, ROT0_ROW0_RST}, 32'sd0);
        for (int i = 0; i < 16; i++)
        begin
            s = random_req();
            s.mode = $urandom_range(0, 1) ? MODE_FINGER1 : MODE_FINGER0;
            s.sample_time = {1'b1, 30'($urandom), 32'($urandom)};
            send(s);
        end
        // stamp saturation
        send(wrench_req(MODE_FINGER0, 65536, 0, 65536, 0, 0, 0, TIME_MAX - 63'd500));
        send(wrench_req(MODE_FINGER1, 0, 65536, -65536, 0, 0, 0, 63'd7));
        send(wrench_req(MODE_FINGER0, 1, 2, 3, 4, 5, 6, TIME_MAX));
        send(wrench_req(MODE_FINGER1, -6, -5, -4, -3, -2, -1, 63'd0));

        drain();
        model.close_out();
        if (model.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tfwc_pkg.sv
rtl/core/two_finger_wrench_combiner_top.sv
bench/tb_grasp_pkg.sv
bench/tb_top.sv
